// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge; skipped while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same check, but reports a caller-supplied message.
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

// ===== rtl/rirt_pkg.sv =====
// Types and constants for the recent ID ring table.
package rirt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ID_W        = 16;
  localparam int unsigned HELD_W      = 5;

  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_LOOKUP    = 2'd1,
    OP_NEXT_FREE = 2'd2
  } op_e;

  typedef struct packed {
    op_e             opcode;
    logic [ID_W-1:0] id_value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic              added;
    logic [ID_W-1:0]   result_id;
    logic [HELD_W-1:0] entries_held;
  } rsp_t;

  // Top level -> scan unit
  typedef struct packed {
    logic             start;
    logic [ID_W-1:0]  key;
    logic [CNT_W-1:0] count;
  } scan_cmd_t;

  // Scan unit -> top level
  typedef struct packed {
    logic done;
    logic hit;
  } scan_rsp_t;

endpackage

// ===== rtl/rirt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rirt_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rirt_scan.sv =====
// Shared compare unit: walks the valid entries looking for one key.
`include "assert_macros.svh"

module rirt_scan
  import rirt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scan_cmd_t        cmd_i,
  output scan_rsp_t        rsp_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  logic [ID_W-1:0]  rd_data_i
);

  logic             busy_q;
  logic             cmp_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ID_W-1:0]  key_q;
  logic             done_q;
  logic             hit_q;

  logic issue;
  logic match;

  // Read issued this cycle, compared the next (registered RAM read).
  assign issue     = busy_q && (idx_q < cnt_q);
  assign match     = busy_q && cmp_q && (rd_data_i == key_q);
  assign rd_addr_o = idx_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cmp_q  <= 1'b0;
      idx_q  <= '0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cmp_q  <= 1'b0;
        idx_q  <= '0;
      end else if (busy_q) begin
        cmp_q <= issue;
        if (issue) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (match) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          hit_q  <= 1'b1;
        end else if (!issue) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          hit_q  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= cmd_i.key;
      cnt_q <= cmd_i.count;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hit  = hit_q;

  `ASSERT_CLK(a_start_when_free, clk_i, rst_ni, cmd_i.start |-> !busy_q)
  `ASSERT_CLK(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `ASSERT_CLK(a_idx_in_range, clk_i, rst_ni, busy_q |-> (idx_q <= cnt_q))

endmodule

// ===== rtl/recent_id_ring_table.sv =====
// Recent ID ring table: top level with request sequencer, ring state and result register.
// Add/lookup: one scan of the valid entries, then FIN loads the result register.
// Next free: up to TABLE_DEPTH + 1 scans (the key, then candidates from key + 1), then FIN.
// Throughput: one transaction at a time; the single compare unit walks the RAM read port.
// Reset clears write slot, entry count and control; table contents are not cleared.
// A queued result may wait in the output register while the next transaction is taken.
`include "assert_macros.svh"

module recent_id_ring_table
  import rirt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SRCH,
    S_FIN
  } state_e;

  state_e           state_q;
  op_e              op_q;
  logic [ID_W-1:0]  id_q;
  logic [ID_W-1:0]  cand_q;
  logic [IDX_W-1:0] tries_q;
  logic             found_q;
  logic             added_q;
  logic [ID_W-1:0]  res_q;
  logic [IDX_W-1:0] slot_q;
  logic [CNT_W-1:0] count_q;
  logic             out_valid_q;
  rsp_t             out_data_q;

  logic             accept;
  logic             out_free;
  logic             do_write;
  scan_cmd_t        scan_cmd;
  scan_rsp_t        scan_rsp;
  logic [IDX_W-1:0] rd_addr;
  logic [ID_W-1:0]  rd_data;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // New entry stored when an add scan finishes without a hit.
  assign do_write = (state_q == S_SCAN) && scan_rsp.done && !scan_rsp.hit &&
                    (op_q == OP_ADD);

  // Scan launch: on acceptance, on the first candidate, and on each retry.
  always_comb begin
    scan_cmd.start = 1'b0;
    scan_cmd.key   = in_data_i.id_value;
    scan_cmd.count = count_q;
    case (state_q)
      S_IDLE: begin
        scan_cmd.start = accept;
      end
      S_SCAN: begin
        scan_cmd.start = scan_rsp.done && (op_q == OP_NEXT_FREE);
        scan_cmd.key   = id_q + ID_W'(1);
      end
      S_SRCH: begin
        scan_cmd.start = scan_rsp.done && scan_rsp.hit &&
                         (tries_q != IDX_W'(TABLE_DEPTH - 1));
        scan_cmd.key   = cand_q + ID_W'(1);
      end
      default: begin
        scan_cmd.start = 1'b0;
      end
    endcase
  end

  rirt_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (scan_cmd),
    .rsp_o     (scan_rsp),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  rirt_ram #(
    .Width (ID_W),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (slot_q),
    .wdata_i (id_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Result register: load from FIN, else drop once taken.
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_rsp.done) begin
            if (do_write) begin
              // Ring write pointer wraps; count saturates at full.
              if (slot_q == IDX_W'(TABLE_DEPTH - 1)) begin
                slot_q <= '0;
              end else begin
                slot_q <= slot_q + IDX_W'(1);
              end
              if (count_q != CNT_W'(TABLE_DEPTH)) begin
                count_q <= count_q + CNT_W'(1);
              end
            end
            state_q <= (op_q == OP_NEXT_FREE) ? S_SRCH : S_FIN;
          end
        end
        S_SRCH: begin
          if (scan_rsp.done && !scan_cmd.start) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_data_i.opcode;
      id_q    <= in_data_i.id_value;
      res_q   <= in_data_i.id_value;
      added_q <= 1'b0;
    end
    if (state_q == S_SCAN && scan_rsp.done) begin
      found_q <= scan_rsp.hit;
      added_q <= do_write;
      cand_q  <= id_q + ID_W'(1);
      tries_q <= '0;
    end
    if (state_q == S_SRCH && scan_rsp.done) begin
      if (!scan_rsp.hit) begin
        res_q <= cand_q;
      end else if (tries_q == IDX_W'(TABLE_DEPTH - 1)) begin
        // Every try hit: step once more, unchecked.
        res_q <= cand_q + ID_W'(1);
      end else begin
        cand_q  <= cand_q + ID_W'(1);
        tries_q <= tries_q + IDX_W'(1);
      end
    end
    if (state_q == S_FIN && out_free) begin
      out_data_q.found        <= found_q;
      out_data_q.added        <= added_q;
      out_data_q.result_id    <= res_q;
      out_data_q.entries_held <= HELD_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(TABLE_DEPTH))
  `ASSERT_CLK(a_add_not_found, clk_i, rst_ni,
              out_valid_q |-> !(out_data_q.added && out_data_q.found))
  `ASSERT_CLK_MSG(a_write_only_add, clk_i, rst_ni,
                  do_write |-> (op_q == OP_ADD), "table write outside an add")

endmodule
